/* src/tks_pkg.sv */
`timescale 1ns / 1ps

package tks_pkg;

   // Storage sizing.
   localparam int SLOTS       = 16;
   localparam int LABEL_COUNT = 8192;

   localparam int SCORE_W = 32;
   localparam int LABEL_W = $clog2(LABEL_COUNT);
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);

   // Configuration register file.
   localparam int K_W    = 5;
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam int REG_W  = ADDR_W - 2;

   localparam logic [REG_W-1:0] REG_K_IN_USE = '0;
   localparam logic [K_W-1:0]   K_RESET      = K_W'(16);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   // Operation requested from the shared compare unit.
   typedef struct packed {
      logic load;    // take the slot data as the first minimum candidate
      logic update;  // take the slot data if it is below the running minimum
      logic decide;  // compare the running minimum against the held item
   } min_op_type;

   // Slot memory control from the sequencer.
   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [SCORE_W-1:0] wr_score;
      logic [LABEL_W-1:0] wr_label;
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
   } mem_ctl_type;

   // A K of zero acts as one, and a K above the slot count acts as the slot count.
   function automatic logic [CNT_W-1:0] effective_k(input logic [K_W-1:0] k);
      logic [CNT_W-1:0] result;
      if (k == '0) begin
         result = CNT_W'(1);
      end else if (int'(k) > SLOTS) begin
         result = CNT_W'(SLOTS);
      end else begin
         result = CNT_W'(k);
      end
      return result;
   endfunction

endpackage

/* src/tks_slot_mem.sv */
`timescale 1ns / 1ps

// Slot storage: one write port and one read port with registered read data.
module tks_slot_mem (
   input  logic                          clock,
   input  tks_pkg::mem_ctl_type          ctl,
   output logic [tks_pkg::SCORE_W-1:0]   rd_score,
   output logic [tks_pkg::LABEL_W-1:0]   rd_label
);

   logic [tks_pkg::SCORE_W-1:0] slot_score_ff [tks_pkg::SLOTS];
   logic [tks_pkg::LABEL_W-1:0] slot_label_ff [tks_pkg::SLOTS];
   logic [tks_pkg::SCORE_W-1:0] rd_score_ff;
   logic [tks_pkg::LABEL_W-1:0] rd_label_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         slot_score_ff[ctl.wr_addr] <= ctl.wr_score;
         slot_label_ff[ctl.wr_addr] <= ctl.wr_label;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_score_ff <= slot_score_ff[ctl.rd_addr];
         rd_label_ff <= slot_label_ff[ctl.rd_addr];
      end
   end

   assign rd_score = rd_score_ff;
   assign rd_label = rd_label_ff;

endmodule

/* src/tks_min_unit.sv */
`timescale 1ns / 1ps

// Running minimum tracker built around a single magnitude comparator.
module tks_min_unit (
   input  logic                          clock,
   input  tks_pkg::min_op_type           op,
   input  logic [tks_pkg::SCORE_W-1:0]   rd_score,
   input  logic [tks_pkg::IDX_W-1:0]     scan_idx,
   input  logic [tks_pkg::SCORE_W-1:0]   item_score,
   output logic [tks_pkg::IDX_W-1:0]     min_pos,
   output logic                          replace
);

   logic [tks_pkg::SCORE_W-1:0] min_score_ff;
   logic [tks_pkg::SCORE_W-1:0] min_score_in;
   logic [tks_pkg::IDX_W-1:0]   min_pos_ff;
   logic [tks_pkg::IDX_W-1:0]   min_pos_in;
   logic [tks_pkg::SCORE_W-1:0] cmp_a;
   logic [tks_pkg::SCORE_W-1:0] cmp_b;
   logic                        less;

   // During the scan the comparator asks whether the slot is below the minimum;
   // at the decision it asks whether the minimum is below the new score.
   assign cmp_a = op.decide ? min_score_ff : rd_score;
   assign cmp_b = op.decide ? item_score   : min_score_ff;
   assign less  = cmp_a < cmp_b;

   always_comb begin
      min_score_in = min_score_ff;
      min_pos_in   = min_pos_ff;
      if (op.load || (op.update && less)) begin
         min_score_in = rd_score;
         min_pos_in   = scan_idx;
      end
   end

   always_ff @(posedge clock) begin
      min_score_ff <= min_score_in;
      min_pos_ff   <= min_pos_in;
   end

   assign min_pos = min_pos_ff;
   assign replace = op.decide && less;

endmodule

/* src/tks_seq.sv */
`timescale 1ns / 1ps

// Sequencer: fills free slots directly, otherwise scans for the minimum, then
// decides on replacement, and drains the store on the final item.
module tks_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tks_pkg::SCORE_W-1:0]   req_score,
   input  logic [tks_pkg::LABEL_W-1:0]   req_label,
   input  logic                          req_is_last,
   input  logic [tks_pkg::CNT_W-1:0]     k_eff,
   output tks_pkg::mem_ctl_type          mem_ctl,
   output tks_pkg::min_op_type           min_op,
   output logic [tks_pkg::IDX_W-1:0]     scan_idx,
   output logic [tks_pkg::SCORE_W-1:0]   item_score,
   input  logic [tks_pkg::IDX_W-1:0]     min_pos,
   input  logic                          replace,
   output logic                          rsp_valid,
   output logic                          rsp_last
);

   tks_pkg::state_type          state_ff, state_in;
   logic [tks_pkg::CNT_W-1:0]   filled_ff, filled_in;
   logic [tks_pkg::IDX_W-1:0]   cnt_ff, cnt_in;
   logic [tks_pkg::SCORE_W-1:0] item_score_ff, item_score_in;
   logic [tks_pkg::LABEL_W-1:0] item_label_ff, item_label_in;
   logic                        item_last_ff, item_last_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        at_end;

   assign at_end = (tks_pkg::CNT_W'(cnt_ff) == (filled_ff - tks_pkg::CNT_W'(1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tks_pkg::ST_IDLE;
         filled_ff    <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      item_score_ff <= item_score_in;
      item_label_ff <= item_label_in;
      item_last_ff  <= item_last_in;
   end

   always_comb begin
      state_in         = state_ff;
      filled_in        = filled_ff;
      cnt_in           = cnt_ff;
      item_score_in    = item_score_ff;
      item_label_in    = item_label_ff;
      item_last_in     = item_last_ff;
      rsp_valid_in     = 1'b0;
      rsp_last_in      = 1'b0;
      min_op           = '0;
      mem_ctl          = '0;
      mem_ctl.wr_score = item_score_ff;
      mem_ctl.wr_label = item_label_ff;
      mem_ctl.rd_addr  = cnt_ff + tks_pkg::IDX_W'(1);

      case (state_ff)
         tks_pkg::ST_IDLE: begin
            if (start) begin
               item_score_in = req_score;
               item_label_in = req_label;
               item_last_in  = req_is_last;
               cnt_in        = '0;
               if (filled_ff < k_eff) begin
                  mem_ctl.wr_en    = 1'b1;
                  mem_ctl.wr_addr  = filled_ff[tks_pkg::IDX_W-1:0];
                  mem_ctl.wr_score = req_score;
                  mem_ctl.wr_label = req_label;
                  filled_in        = filled_ff + tks_pkg::CNT_W'(1);
                  if (req_is_last) begin
                     state_in = tks_pkg::ST_EMIT;
                  end
               end else begin
                  mem_ctl.rd_en   = 1'b1;
                  mem_ctl.rd_addr = '0;
                  state_in        = tks_pkg::ST_SCAN;
               end
            end
         end
         tks_pkg::ST_SCAN: begin
            min_op.load   = (cnt_ff == '0);
            min_op.update = (cnt_ff != '0);
            if (at_end) begin
               state_in = tks_pkg::ST_DECIDE;
            end else begin
               mem_ctl.rd_en = 1'b1;
               cnt_in        = cnt_ff + tks_pkg::IDX_W'(1);
            end
         end
         tks_pkg::ST_DECIDE: begin
            min_op.decide = 1'b1;
            if (replace) begin
               mem_ctl.wr_en   = 1'b1;
               mem_ctl.wr_addr = min_pos;
            end
            cnt_in = '0;
            if (item_last_ff) begin
               state_in = tks_pkg::ST_EMIT;
            end else begin
               state_in = tks_pkg::ST_IDLE;
            end
         end
         tks_pkg::ST_EMIT: begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = cnt_ff;
            rsp_valid_in    = 1'b1;
            if (at_end) begin
               rsp_last_in = 1'b1;
               filled_in   = '0;
               state_in    = tks_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + tks_pkg::IDX_W'(1);
            end
         end
         default: begin
            state_in = tks_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != tks_pkg::ST_IDLE);
   assign scan_idx   = cnt_ff;
   assign item_score = item_score_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_last   = rsp_last_ff;

   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      int'(filled_ff) <= tks_pkg::SLOTS)
      else $error("slot fill count exceeds the slot count");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == tks_pkg::ST_EMIT))
      else $error("result beat without a preceding drain read");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (filled_ff == '0))
      else $error("store not emptied after the final result beat");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |=> !rsp_valid_ff)
      else $error("result beat follows the final beat of a drain");

endmodule

/* src/top_k_select_top.sv */
`timescale 1ns / 1ps

// An item that fills a free slot is absorbed without leaving idle; once K slots are
// filled an item holds busy while the N filled slots are read, one read per cycle, and
// a decision is made. A final item then drains N result beats. A new item is taken only
// while idle, since the single slot read port and the shared comparator serve the scan.
// The receiver cannot stall beats.
// Reset (synchronous, active high) empties the store and sets K to 16.
module top_k_select_top (
   input  logic                          clock,
   input  logic                          reset,

   // Item channel.
   input  logic                          start,
   output logic                          busy,
   input  logic [tks_pkg::SCORE_W-1:0]   req_score,
   input  logic [tks_pkg::LABEL_W-1:0]   req_label,
   input  logic                          req_is_last,

   // Result channel.
   output logic                          rsp_valid,
   output logic [tks_pkg::LABEL_W-1:0]   rsp_out_label,
   output logic [tks_pkg::SCORE_W-1:0]   rsp_out_score,
   output logic                          rsp_out_last,

   // Configuration port.
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tks_pkg::ADDR_W-1:0]    paddr,
   input  logic [tks_pkg::DATA_W-1:0]    pwdata,
   output logic [tks_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   logic [tks_pkg::K_W-1:0]     k_ff, k_in;
   logic                        csr_write;
   logic [tks_pkg::REG_W-1:0]   csr_reg;
   logic [tks_pkg::CNT_W-1:0]   k_eff;
   tks_pkg::mem_ctl_type        mem_ctl;
   tks_pkg::min_op_type         min_op;
   logic [tks_pkg::IDX_W-1:0]   scan_idx;
   logic [tks_pkg::SCORE_W-1:0] item_score;
   logic [tks_pkg::IDX_W-1:0]   min_pos;
   logic                        replace;

   // The register file has a single register, K, at byte offset zero. The port
   // never inserts wait states, and writes to unmapped offsets are dropped.
   assign pready    = 1'b1;
   assign csr_reg   = paddr[tks_pkg::ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      k_in = k_ff;
      if (csr_write && (csr_reg == tks_pkg::REG_K_IN_USE)) begin
         k_in = pwdata[tks_pkg::K_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= tks_pkg::K_RESET;
      end else begin
         k_ff <= k_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_reg == tks_pkg::REG_K_IN_USE) begin
         prdata = tks_pkg::DATA_W'(k_ff);
      end
   end

   // The written value is kept as is for read-back; the clamp to a usable K is
   // applied only where the sequencer consumes it.
   assign k_eff = tks_pkg::effective_k(k_ff);

   // The sequencer owns the fill count and steps the slot reads, one per cycle,
   // both for the minimum search and for draining the store.
   tks_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_score   (req_score),
      .req_label   (req_label),
      .req_is_last (req_is_last),
      .k_eff       (k_eff),
      .mem_ctl     (mem_ctl),
      .min_op      (min_op),
      .scan_idx    (scan_idx),
      .item_score  (item_score),
      .min_pos     (min_pos),
      .replace     (replace),
      .rsp_valid   (rsp_valid),
      .rsp_last    (rsp_out_last)
   );

   // Slot storage. Its registered read data doubles as the result payload
   // register during a drain.
   tks_slot_mem u_mem (
      .clock    (clock),
      .ctl      (mem_ctl),
      .rd_score (rsp_out_score),
      .rd_label (rsp_out_label)
   );

   // The shared comparator first tracks the lowest-indexed minimum over the
   // filled slots, then checks whether the held item strictly beats it.
   tks_min_unit u_min (
      .clock      (clock),
      .op         (min_op),
      .rd_score   (rsp_out_score),
      .scan_idx   (scan_idx),
      .item_score (item_score),
      .min_pos    (min_pos),
      .replace    (replace)
   );

endmodule
